>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the crossover trader.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication check.
`define MAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");
// Next-cycle implication check.
`define MAC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");
`else
`define MAC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MAC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> sv/mac_pkg.sv
// Shared types and constants of the crossover trader.
package mac_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned LEN_REG_W = 9;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [WORD_W-1:0] DEFAULT_CAPITAL = 32'd1000000;
    localparam logic [WORD_W-1:0] WORD_MAX        = 32'hFFFF_FFFF;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Register indexes of the configuration port
    localparam t_cfg_idx CFG_BUY_FAST  = 3'd0;
    localparam t_cfg_idx CFG_BUY_SLOW  = 3'd1;
    localparam t_cfg_idx CFG_SELL_FAST = 3'd2;
    localparam t_cfg_idx CFG_SELL_SLOW = 3'd3;
    localparam t_cfg_idx CFG_HOLD      = 3'd4;
    localparam t_cfg_idx CFG_CAPITAL   = 3'd5;

    // Trade reported with each result
    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_BUY  = 2'd1,
        ACT_SELL = 2'd2
    } t_action;

endpackage

>>> sv/mac_chan_if.sv
// Valid/ready channel interfaces for price items and trade results.
interface mac_in_if import mac_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] price;
    logic              trading;
    logic              final_day;

    modport source (output valid, price, trading, final_day, input ready);
    modport sink   (input valid, price, trading, final_day, output ready);
endinterface

interface mac_out_if import mac_pkg::*; ();
    logic              valid;
    logic              ready;
    t_action           action;
    logic              holding;
    logic [WORD_W-1:0] share_count;
    logic [WORD_W-1:0] cash_value;
    logic              is_last;

    modport source (output valid, action, holding, share_count, cash_value, is_last,
                     input ready);
    modport sink   (input valid, action, holding, share_count, cash_value, is_last,
                    output ready);
endinterface

>>> sv/mac_hist_mem.sv
// Price history memory: one write port, one read port, registered read data.
module mac_hist_mem import mac_pkg::*; #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/mac_div.sv
// Restoring divider, one quotient bit per cycle.
module mac_div import mac_pkg::*; #(
    parameter int unsigned DW = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DW-1:0]     i_dividend,
    input  logic [WORD_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DW-1:0]     o_quotient
);

    localparam int unsigned CNT_W = $clog2(DW + 1);

    logic [DW-1:0]     r_quo;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [WORD_W:0]   w_trial;
    logic              w_fits;

    // shift in the next dividend bit and try the subtraction
    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_cnt  <= CNT_W'(DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_fits ? WORD_W'(w_trial - {1'b0, r_div}) : w_trial[WORD_W-1:0];
                r_quo <= {r_quo[DW-2:0], w_fits};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> sv/moving_average_crossover_trader.sv
// Top level of the dual moving-average crossover trader.
//
// Channels: i_in carries one price item (price, trading, final_day) per
// transfer; o_res returns exactly one result per item (action, holding,
// share_count, cash_value, is_last). Lengths, hold mode and starting capital
// are written through i_cfg_we / i_cfg_idx / i_cfg_data, by the user only
// while idle; the block itself does not enforce it. An item with no trade
// passes from transfer through the window update, history write, multiply,
// compare, finish and output states; a crossover sell adds the two close
// states, a final-day liquidation adds them and a return to the finish
// state, and a buy adds the serial share-count divider and the cost and
// remainder states. Four history reads per item (one per window) go through
// the single read port of the history memory. After a write to any length
// register the next item first sweeps the whole history to rebuild the
// window sums. Reset clears the history fill count, sums and position, and
// loads the balance with 1000000. A finished result sits in an output
// register; a new item is taken while it waits, and a second result waits
// in the sequencer until the receiver takes the first.
module moving_average_crossover_trader import mac_pkg::*; #(
    parameter int unsigned HISTORY_DEPTH       = 256,
    parameter int unsigned PRICE_FRACTION_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mac_in_if.sink            i_in,
    mac_out_if.source         o_res,
    input  logic              i_cfg_we,
    input  t_cfg_idx          i_cfg_idx,
    input  logic [WORD_W-1:0] i_cfg_data
);

    `include "assert_macros.svh"

    localparam int unsigned AW    = $clog2(HISTORY_DEPTH);
    localparam int unsigned CW    = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned XW    = CW + 1;
    localparam int unsigned SW    = WORD_W + $clog2(HISTORY_DEPTH);
    localparam int unsigned PW    = SW + CW;
    localparam int unsigned DW    = WORD_W + PRICE_FRACTION_BITS;
    localparam int unsigned PRODW = 2 * WORD_W;
    localparam int unsigned PXW   = PRODW + 1;
    localparam logic [AW-1:0]  LAST_ADDR = AW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0]  DEPTH_C   = CW'(HISTORY_DEPTH);
    localparam logic [PXW-1:0] ROUND_UP  = (PXW'(1) << PRICE_FRACTION_BITS) - PXW'(1);

    typedef enum logic [12:0] {
        S_IDLE   = 13'h0001,
        S_SWEEP  = 13'h0002,
        S_RDOLD  = 13'h0004,
        S_WR     = 13'h0008,
        S_MUL    = 13'h0010,
        S_CMP    = 13'h0020,
        S_DIV    = 13'h0040,
        S_COST   = 13'h0080,
        S_REM    = 13'h0100,
        S_CLOSE  = 13'h0200,
        S_CLOSE2 = 13'h0400,
        S_FIN    = 13'h0800,
        S_OUT    = 13'h1000
    } t_state;

    t_state r_state;

    // configuration
    logic [LEN_REG_W-1:0] r_len_cfg [4];
    logic                 r_hold_cfg;
    logic [WORD_W-1:0]    r_cap_cfg;
    logic                 r_dirty;

    // history bookkeeping and window sums
    logic [AW-1:0] r_wptr;
    logic [CW-1:0] r_count;
    logic [SW-1:0] r_sum [4];
    logic [PW-1:0] r_p   [4];
    logic [CW-1:0] r_cnt;
    logic [2:0]    r_k;
    logic          r_pend;
    logic [CW-1:0] r_pend_d;
    logic [1:0]    r_pend_k;

    // current item
    logic [WORD_W-1:0] r_price;
    logic              r_trading;
    logic              r_fin;

    // strategy and portfolio state
    logic [1:0]        r_rel;
    logic [1:0]        r_prev_rel;
    logic              r_have_prev;
    logic [1:0]        r_day;
    logic              r_open;
    logic [WORD_W-1:0] r_shares;
    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_money;
    logic [WORD_W-1:0] r_quo32;
    logic [PRODW-1:0]  r_prod;
    logic              r_sell_after;
    logic              r_div_start;
    t_action           r_action;
    logic              r_last;

    // output register
    logic              r_out_valid;
    t_action           r_o_action;
    logic              r_o_holding;
    logic [WORD_W-1:0] r_o_shares;
    logic [WORD_W-1:0] r_o_cash;
    logic              r_o_last;

    logic [CW-1:0]     w_len [4];
    logic [AW-1:0]     w_base;
    logic [AW-1:0]     w_sweep_addr;
    logic [CW-1:0]     w_old_len;
    logic [AW-1:0]     w_old_addr;
    logic [AW-1:0]     w_raddr;
    logic [WORD_W-1:0] w_rdata;
    logic              w_we;
    logic [1:0]        w_rel;
    logic              w_buy_x;
    logic              w_sell_x;
    logic              w_hold_open;
    logic              w_div_done;
    logic [DW-1:0]     w_quo;
    logic [PXW-1:0]    w_cost_full;
    logic [WORD_W-1:0] w_cost;
    logic [PXW-1:0]    w_close_full;
    logic              w_out_free;
    logic              w_out_load;
    logic              w_accept;

    // clamp configured lengths to 1..HISTORY_DEPTH
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_len_cfg[k] == '0) begin
                w_len[k] = CW'(1);
            end else if (32'(r_len_cfg[k]) > HISTORY_DEPTH) begin
                w_len[k] = DEPTH_C;
            end else begin
                w_len[k] = CW'(r_len_cfg[k]);
            end
        end
    end

    // history read addresses: sweep walks back from the newest entry,
    // the update reads the entry that drops out of each window
    always_comb begin
        w_base = (r_wptr == '0) ? LAST_ADDR : r_wptr - AW'(1);
        w_sweep_addr = (XW'(w_base) >= XW'(r_cnt))
                     ? AW'(XW'(w_base) - XW'(r_cnt))
                     : AW'(XW'(w_base) + XW'(HISTORY_DEPTH) - XW'(r_cnt));
        w_old_len  = w_len[r_k[1:0]];
        w_old_addr = (XW'(r_wptr) >= XW'(w_old_len))
                   ? AW'(XW'(r_wptr) - XW'(w_old_len))
                   : AW'(XW'(r_wptr) + XW'(HISTORY_DEPTH) - XW'(w_old_len));
        w_raddr = (r_state == S_SWEEP) ? w_sweep_addr : w_old_addr;
    end

    assign w_we = (r_state == S_WR);

    mac_hist_mem #(
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wptr),
        .i_wdata (r_price),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    mac_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (DW'(r_money) << PRICE_FRACTION_BITS),
        .i_divisor  (r_price),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // crossover relations and trade decisions
    assign w_rel       = {(r_p[2] < r_p[3]), (r_p[0] > r_p[1])};
    assign w_buy_x     = !r_prev_rel[0] && w_rel[0];
    assign w_sell_x    = !r_prev_rel[1] && r_rel[1];
    assign w_hold_open = (r_day == 2'd1) && r_hold_cfg && !r_open;

    // buy cost rounded up, and close value
    assign w_cost_full  = ({1'b0, r_prod} + ROUND_UP) >> PRICE_FRACTION_BITS;
    assign w_cost       = (w_cost_full > PXW'(r_money)) ? r_money : w_cost_full[WORD_W-1:0];
    assign w_close_full = PXW'(r_prod >> PRICE_FRACTION_BITS) + PXW'(r_rem);

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_out_load = (r_state == S_OUT) && w_out_free;
    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg[0] <= LEN_REG_W'(1);
            r_len_cfg[1] <= LEN_REG_W'(2);
            r_len_cfg[2] <= LEN_REG_W'(1);
            r_len_cfg[3] <= LEN_REG_W'(2);
            r_hold_cfg   <= 1'b0;
            r_cap_cfg    <= DEFAULT_CAPITAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BUY_FAST:  r_len_cfg[0] <= i_cfg_data[LEN_REG_W-1:0];
                CFG_BUY_SLOW:  r_len_cfg[1] <= i_cfg_data[LEN_REG_W-1:0];
                CFG_SELL_FAST: r_len_cfg[2] <= i_cfg_data[LEN_REG_W-1:0];
                CFG_SELL_SLOW: r_len_cfg[3] <= i_cfg_data[LEN_REG_W-1:0];
                CFG_HOLD:      r_hold_cfg   <= i_cfg_data[0];
                CFG_CAPITAL:   r_cap_cfg    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dirty     <= 1'b0;
            r_wptr      <= '0;
            r_count     <= '0;
            for (int k = 0; k < 4; k++) r_sum[k] <= '0;
            r_pend      <= 1'b0;
            r_div_start <= 1'b0;
            r_prev_rel  <= '0;
            r_have_prev <= 1'b0;
            r_day       <= '0;
            r_open      <= 1'b0;
            r_shares    <= '0;
            r_rem       <= '0;
            r_money     <= DEFAULT_CAPITAL;
            r_out_valid <= 1'b0;
        end else begin
            // result register: load on completion, drop once taken
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_BUY_FAST || i_cfg_idx == CFG_BUY_SLOW ||
                             i_cfg_idx == CFG_SELL_FAST || i_cfg_idx == CFG_SELL_SLOW)) begin
                r_dirty <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_price   <= i_in.price;
                        r_trading <= i_in.trading;
                        r_fin     <= i_in.final_day;
                        r_action  <= ACT_NONE;
                        r_last    <= 1'b0;
                        r_cnt     <= '0;
                        r_k       <= '0;
                        r_pend    <= 1'b0;
                        if (r_dirty) begin
                            for (int k = 0; k < 4; k++) r_sum[k] <= '0;
                            r_state <= S_SWEEP;
                        end else begin
                            r_state <= S_RDOLD;
                        end
                    end
                end

                // rebuild all sums from the stored history
                S_SWEEP: begin
                    if (r_cnt < DEPTH_C) begin
                        r_pend   <= 1'b1;
                        r_pend_d <= r_cnt;
                        r_cnt    <= r_cnt + CW'(1);
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        for (int k = 0; k < 4; k++) begin
                            if (r_pend_d < w_len[k] && r_pend_d < r_count) begin
                                r_sum[k] <= r_sum[k] + SW'(w_rdata);
                            end
                        end
                    end
                    if (r_cnt == DEPTH_C && !r_pend) begin
                        r_dirty <= 1'b0;
                        r_state <= S_RDOLD;
                    end
                end

                // slide each window: add new price, drop the oldest entry once the window is full
                S_RDOLD: begin
                    if (r_k < 3'd4) begin
                        r_pend   <= 1'b1;
                        r_pend_k <= r_k[1:0];
                        r_k      <= r_k + 3'd1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        r_sum[r_pend_k] <= r_sum[r_pend_k] + SW'(r_price)
                                         - ((w_len[r_pend_k] <= r_count) ? SW'(w_rdata) : '0);
                    end
                    if (r_k == 3'd4 && !r_pend) begin
                        r_state <= S_WR;
                    end
                end

                S_WR: begin
                    r_wptr <= (r_wptr == LAST_ADDR) ? '0 : r_wptr + AW'(1);
                    if (r_count != DEPTH_C) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= S_MUL;
                end

                // cross-multiplied averages
                S_MUL: begin
                    r_p[0]  <= PW'(r_sum[0]) * PW'(w_len[1]);
                    r_p[1]  <= PW'(r_sum[1]) * PW'(w_len[0]);
                    r_p[2]  <= PW'(r_sum[2]) * PW'(w_len[3]);
                    r_p[3]  <= PW'(r_sum[3]) * PW'(w_len[2]);
                    r_state <= S_CMP;
                end

                S_CMP: begin
                    r_rel <= w_rel;
                    priority if (!r_trading) begin
                        r_state <= S_FIN;
                    end else if (!r_have_prev) begin
                        // run start
                        r_money  <= r_cap_cfg;
                        r_open   <= 1'b0;
                        r_shares <= '0;
                        r_rem    <= '0;
                        r_state  <= S_FIN;
                    end else if (w_hold_open || (!r_open && w_buy_x)) begin
                        r_sell_after <= w_hold_open;
                        if (r_price == '0) begin
                            r_quo32 <= WORD_MAX;
                            r_state <= S_COST;
                        end else begin
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV;
                        end
                    end else if (r_open && !r_prev_rel[1] && w_rel[1]) begin
                        r_state <= S_CLOSE;
                    end else begin
                        r_state <= S_FIN;
                    end
                end

                S_DIV: begin
                    r_div_start <= 1'b0;
                    if (w_div_done) begin
                        r_quo32 <= (w_quo > DW'(WORD_MAX)) ? WORD_MAX : w_quo[WORD_W-1:0];
                        r_state <= S_COST;
                    end
                end

                S_COST: begin
                    r_prod  <= PRODW'(r_quo32) * PRODW'(r_price);
                    r_state <= S_REM;
                end

                // open the position
                S_REM: begin
                    r_shares <= r_quo32;
                    r_rem    <= r_money - w_cost;
                    r_open   <= 1'b1;
                    r_action <= ACT_BUY;
                    r_state  <= (r_sell_after && w_sell_x) ? S_CLOSE : S_FIN;
                end

                S_CLOSE: begin
                    r_prod  <= PRODW'(r_shares) * PRODW'(r_price);
                    r_state <= S_CLOSE2;
                end

                // close the position, saturating the balance
                S_CLOSE2: begin
                    r_money  <= (w_close_full > PXW'(WORD_MAX)) ? WORD_MAX
                                                                : w_close_full[WORD_W-1:0];
                    r_shares <= '0;
                    r_rem    <= '0;
                    r_open   <= 1'b0;
                    r_action <= ACT_SELL;
                    r_state  <= S_FIN;
                end

                // liquidation and run bookkeeping
                S_FIN: begin
                    if (r_trading && r_fin && r_open) begin
                        r_state <= S_CLOSE;
                    end else begin
                        if (r_trading) begin
                            if (r_fin) begin
                                r_last      <= 1'b1;
                                r_day       <= '0;
                                r_have_prev <= 1'b0;
                                r_prev_rel  <= '0;
                            end else begin
                                r_prev_rel  <= r_rel;
                                r_have_prev <= 1'b1;
                                if (r_day != 2'd2) begin
                                    r_day <= r_day + 2'd1;
                                end
                            end
                        end
                        r_state <= S_OUT;
                    end
                end

                S_OUT: begin
                    if (w_out_free) begin
                        r_o_action  <= r_action;
                        r_o_holding <= r_open;
                        r_o_shares  <= r_shares;
                        r_o_cash    <= r_money;
                        r_o_last    <= r_last;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.action      = r_o_action;
    assign o_res.holding     = r_o_holding;
    assign o_res.share_count = r_o_shares;
    assign o_res.cash_value  = r_o_cash;
    assign o_res.is_last     = r_o_last;

    // checks
    `MAC_ASSERT_IMP(a_div_done_in_wait, i_clk, i_rst_n, w_div_done, r_state == S_DIV)
    `MAC_ASSERT_IMP(a_flat_is_clean, i_clk, i_rst_n, !r_open, (r_shares == '0) && (r_rem == '0))
    `MAC_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, w_out_load, r_out_valid && (r_state == S_IDLE))
    `MAC_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_C)

endmodule
